[hdl/assert_macros.svh]
// Assertion macros shared by the lamp-drive register block.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while reset is released.
`define LDIO_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("ldio assertion failed");

// Check a property at every edge, reset included.
`define LDIO_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ldio assertion failed");

`endif

[hdl/ldio_pkg.sv]
// Types, codes and helper functions for the lamp-drive register block.
// No dependencies; imported by every module of the block.
package ldio_pkg;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 72;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    // Bus offsets
    localparam logic [3:0] OFF_DSP_RESULT = 4'h1;
    localparam logic [3:0] OFF_DSP_STATUS = 4'h2;
    localparam logic [3:0] OFF_HIGH_SIDE  = 4'h1;
    localparam logic [3:0] OFF_LEDS       = 4'h3;
    localparam logic [3:0] OFF_LOW_SIDE   = 4'h5;
    localparam logic [3:0] OFF_COIN       = 4'h7;
    localparam logic [3:0] OFF_METERS     = 4'h9;
    localparam logic [3:0] OFF_STATUS     = 4'hB;
    localparam logic [3:0] OFF_CRC        = 4'hD;
    localparam logic [3:0] OFF_CRC_LO_A   = 4'h8;
    localparam logic [3:0] OFF_CRC_LO_B   = 4'hA;
    localparam logic [3:0] OFF_BOARD_REV  = 4'hB;
    localparam logic [3:0] OFF_INPUTS     = 4'hD;
    localparam logic [3:0] OFF_ALL_ONES   = 4'hE;
    localparam logic [3:0] OFF_COIN_IN    = 4'hF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DSP_RESULT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DSP_STATUS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DSP_READY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DSP_REV    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_REV  = 3'd4;

    // Change mask bit positions
    localparam int unsigned CHG_HIGH   = 0;
    localparam int unsigned CHG_LEDS   = 1;
    localparam int unsigned CHG_LOW    = 2;
    localparam int unsigned CHG_COIN   = 3;
    localparam int unsigned CHG_METERS = 4;
    localparam int unsigned CHG_STATUS = 5;

    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  DSP_RESULT_RST  = 8'h99;
    localparam logic [7:0]  LOW_SIDE_RST    = 8'hFF;
    localparam logic [7:0]  NOT_READY_FLAG  = 8'h80;
    localparam logic [7:0]  ALL_ONES        = 8'hFF;

    typedef struct packed {
        logic [3:0] pin_inputs;
        logic [7:0] coin_inputs;
        logic [3:0] switch_nibble;
        logic [7:0] write_data;
        logic [3:0] offset;
        logic       mode;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status_leds;
        logic [7:0] meter_drive;
        logic [7:0] coin_lockout;
        logic [3:0] led_strobe_index;
        logic [7:0] led_drive;
        logic [3:0] low_strobe_index;
        logic [7:0] low_side_drive;
        logic [7:0] high_side_drive;
        logic       dsp_command;
        logic [5:0] change_mask;
        logic [7:0] read_data;
    } t_out_item;

    typedef struct packed {
        logic [7:0] dsp_result_value;
        logic [7:0] dsp_status_value;
        logic       dsp_ready;
        logic [6:0] dsp_revision;
        logic [7:0] board_revision;
    } t_cfg;

    // Position of the single set bit plus one; zero when not exactly one bit.
    function automatic logic [3:0] onehot_index(input logic [7:0] v);
        logic [3:0] idx;
        idx = '0;
        if (v != 8'd0 && (v & (v - 8'd1)) == 8'd0) begin
            for (int k = 0; k < 8; k++) begin
                if (v[k]) begin
                    idx = 4'(k + 1);
                end
            end
        end
        return idx;
    endfunction

    // Reflected CRC-16 byte step, LSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (c[0] ^ b[i]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[hdl/lamp_drive_io_asic_registers_unit.sv]
// Path: a bus word waits in the input register until the core advances it into the result
// register, from which its result is offered. Throughput: one word per cycle unless the
// result side stalls; the CRC byte step and the read mux are combinational.
// Reset: synchronous, active low; drivers clear, low side goes to 0xFF, CRC clears,
// DSP result config returns to 0x99, other config to zero; both readies stay low in reset.
// Results are registered, so a new word is taken while a finished result waits.
module lamp_drive_io_asic_registers_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // bus access stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [3:0] offset, [11:4] write_data, [15:12] switch_nibble,
    // [23:16] coin_inputs, [27:24] pin_inputs, [31:28] zero
    input  logic [ldio_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // [0] mode (1 write, 0 read)
    input  logic                             i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] read_data, [13:8] change_mask, [14] dsp_command,
    // [22:15] high_side_drive, [30:23] low_side_drive, [34:31] low_strobe_index,
    // [42:35] led_drive, [46:43] led_strobe_index, [54:47] coin_lockout,
    // [62:55] meter_drive, [64:63] status_leds, [71:65] zero
    output logic [ldio_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ldio_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ldio_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ldio_pkg::*;

    `include "assert_macros.svh"

    t_in_item  s_in_item;
    t_in_item  held_item;
    logic      held_valid;
    logic      advance;
    t_cfg      cfg;
    t_out_item out_item;
    logic      read_hit;
    logic      result_quiet;
    logic      led_strobed;

    // Unpack the incoming word into named fields.
    assign s_in_item.mode          = i_s_axis_tuser;
    assign s_in_item.offset        = i_s_axis_tdata[3:0];
    assign s_in_item.write_data    = i_s_axis_tdata[11:4];
    assign s_in_item.switch_nibble = i_s_axis_tdata[15:12];
    assign s_in_item.coin_inputs   = i_s_axis_tdata[23:16];
    assign s_in_item.pin_inputs    = i_s_axis_tdata[27:24];

    ldio_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Hold the accepted word until the core takes it.
    ldio_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (s_in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    // Update the driver state and register the result in the same edge.
    ldio_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (held_valid),
        .i_item    (held_item),
        .i_cfg     (cfg),
        .o_advance (advance),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_item    (out_item)
    );

    // Pack the result word; the struct's last field sits at the low bit, as the port lists it.
    assign o_m_axis_tdata = {{(OUT_TDATA_W - $bits(t_out_item)){1'b0}}, out_item};

    assign read_hit     = o_m_axis_tvalid && (out_item.read_data != 8'd0);
    assign result_quiet = (out_item.change_mask == 6'd0) && !out_item.dsp_command;
    assign led_strobed  = o_m_axis_tvalid && (out_item.led_strobe_index != 4'd0);

    // A word held in the input register stays until the core advances it.
    `LDIO_ASSERT(a_hold_input, i_clk, i_rst_n, (held_valid && !advance) |=> held_valid)
    // Reset leaves no result pending.
    `LDIO_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_axis_tvalid)
    // Only a write reports changes, and a write reads back zero.
    `LDIO_ASSERT(a_read_no_change, i_clk, i_rst_n, read_hit |-> result_quiet)
    // A nonzero LED strobe index implies a single lit column.
    `LDIO_ASSERT(a_led_onehot, i_clk, i_rst_n, led_strobed |-> $onehot(out_item.led_drive))

endmodule

[hdl/ldio_cfg_regs.sv]
// Configuration registers of the lamp-drive register block.
// Depends on ldio_pkg.
module ldio_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ldio_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ldio_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output ldio_pkg::t_cfg                 o_cfg
);
    import ldio_pkg::*;

    t_cfg r_cfg;

    // Refuse writes while reset holds the registers.
    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dsp_result_value <= DSP_RESULT_RST;
            r_cfg.dsp_status_value <= '0;
            r_cfg.dsp_ready        <= 1'b0;
            r_cfg.dsp_revision     <= '0;
            r_cfg.board_revision   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DSP_RESULT: r_cfg.dsp_result_value <= i_cfg_data;
                CFG_DSP_STATUS: r_cfg.dsp_status_value <= i_cfg_data;
                CFG_DSP_READY:  r_cfg.dsp_ready        <= i_cfg_data[0];
                CFG_DSP_REV:    r_cfg.dsp_revision     <= i_cfg_data[6:0];
                CFG_BOARD_REV:  r_cfg.board_revision   <= i_cfg_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end
endmodule

[hdl/ldio_in_stage.sv]
// Input register of the lamp-drive register block.
// Depends on ldio_pkg.
module ldio_in_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  ldio_pkg::t_in_item i_item,
    input  logic               i_advance,
    output logic               o_valid,
    output ldio_pkg::t_in_item o_item
);
    import ldio_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // Take a new word when empty or when the held one moves on this cycle;
    // take nothing while in reset.
    assign o_ready = i_rst_n && (!r_valid || i_advance);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end
endmodule

[hdl/ldio_core.sv]
// Register file, CRC and read mux of the lamp-drive block, with result register.
// Depends on ldio_pkg.
module ldio_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  ldio_pkg::t_in_item  i_item,
    input  ldio_pkg::t_cfg      i_cfg,
    output logic                o_advance,
    output logic                o_valid,
    input  logic                i_ready,
    output ldio_pkg::t_out_item o_item
);
    import ldio_pkg::*;

    logic [7:0]  r_high, n_high;
    logic [7:0]  r_low, n_low;
    logic [3:0]  r_low_idx, n_low_idx;
    logic [7:0]  r_led, n_led;
    logic [3:0]  r_led_idx, n_led_idx;
    logic [7:0]  r_coin, n_coin;
    logic [7:0]  r_meter, n_meter;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_crc, n_crc;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [7:0]  rd;
    logic [5:0]  mask;
    logic        cmd;

    assign o_advance = i_valid && (!r_out_valid || i_ready);
    assign o_valid   = r_out_valid;
    assign o_item    = r_out;

    always_comb begin
        n_high    = r_high;
        n_low     = r_low;
        n_low_idx = r_low_idx;
        n_led     = r_led;
        n_led_idx = r_led_idx;
        n_coin    = r_coin;
        n_meter   = r_meter;
        n_status  = r_status;
        n_crc     = r_crc;
        rd        = '0;
        mask      = '0;
        cmd       = 1'b0;
        if (i_item.mode) begin
            case (i_item.offset)
                OFF_HIGH_SIDE: begin
                    mask[CHG_HIGH] = (r_high != i_item.write_data);
                    n_high         = i_item.write_data;
                end
                OFF_LEDS: begin
                    mask[CHG_LEDS] = (r_led != i_item.write_data);
                    n_led          = i_item.write_data;
                    n_led_idx      = onehot_index(i_item.write_data);
                end
                OFF_LOW_SIDE: begin
                    mask[CHG_LOW] = (r_low != i_item.write_data);
                    n_low         = i_item.write_data;
                    n_low_idx     = onehot_index(~i_item.write_data);
                end
                OFF_COIN: begin
                    mask[CHG_COIN] = (r_coin != i_item.write_data);
                    n_coin         = i_item.write_data;
                end
                OFF_METERS: begin
                    mask[CHG_METERS] = (r_meter != i_item.write_data);
                    n_meter          = i_item.write_data;
                end
                OFF_STATUS: begin
                    mask[CHG_STATUS] = (r_status != i_item.write_data[5:4]);
                    n_status         = i_item.write_data[5:4];
                    cmd              = i_item.write_data[6];
                end
                OFF_CRC: begin
                    n_crc = crc_byte(r_crc, i_item.write_data);
                end
                default: begin
                end
            endcase
        end else begin
            case (i_item.offset)
                OFF_DSP_RESULT: rd = i_cfg.dsp_result_value;
                OFF_DSP_STATUS: rd = i_cfg.dsp_ready ? i_cfg.dsp_status_value
                                                     : (NOT_READY_FLAG |
                                                        {1'b0, i_cfg.dsp_revision});
                OFF_CRC_LO_A, OFF_CRC_LO_B: rd = r_crc[7:0];
                OFF_BOARD_REV:  rd = i_cfg.board_revision;
                OFF_INPUTS:     rd = {i_item.switch_nibble, i_item.pin_inputs};
                OFF_ALL_ONES:   rd = ALL_ONES;
                OFF_COIN_IN:    rd = ~i_item.coin_inputs;
                default:        rd = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high      <= '0;
            r_low       <= LOW_SIDE_RST;
            r_low_idx   <= '0;
            r_led       <= '0;
            r_led_idx   <= '0;
            r_coin      <= '0;
            r_meter     <= '0;
            r_status    <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_high    <= n_high;
                r_low     <= n_low;
                r_low_idx <= n_low_idx;
                r_led     <= n_led;
                r_led_idx <= n_led_idx;
                r_coin    <= n_coin;
                r_meter   <= n_meter;
                r_status  <= n_status;
                r_crc     <= n_crc;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_out.read_data        <= rd;
            r_out.change_mask      <= mask;
            r_out.dsp_command      <= cmd;
            r_out.high_side_drive  <= n_high;
            r_out.low_side_drive   <= n_low;
            r_out.low_strobe_index <= n_low_idx;
            r_out.led_drive        <= n_led;
            r_out.led_strobe_index <= n_led_idx;
            r_out.coin_lockout     <= n_coin;
            r_out.meter_drive      <= n_meter;
            r_out.status_leds      <= n_status;
        end
    end
endmodule

[test/lamp_drive_io_asic_registers_unit_tb.sv]
// Self-checking testbench for the lamp-drive register block: bus words in, result words out.
// Predicts every result in-line and compares it field by field; needs ldio_pkg and the top level.
module lamp_drive_io_asic_registers_unit_tb;
    import ldio_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    // Bus access kinds carried in tuser
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Offsets with no register behind them
    localparam logic [3:0] OFF_SPARE_LO = 4'h0;
    localparam logic [3:0] OFF_SPARE_HI = 4'hC;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata = '0;
    logic                   i_s_axis_tuser = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    lamp_drive_io_asic_registers_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Shadow of the block: latched drivers, CRC and the register settings.
    logic [7:0]  high_side_q = 8'h00;
    logic [7:0]  low_side_q  = LOW_SIDE_RST;
    logic [3:0]  low_idx_q   = 4'd0;
    logic [7:0]  led_q       = 8'h00;
    logic [3:0]  led_idx_q   = 4'd0;
    logic [7:0]  coin_q      = 8'h00;
    logic [7:0]  meter_q     = 8'h00;
    logic [1:0]  status_q    = 2'd0;
    logic [15:0] crc_q       = 16'h0000;
    t_cfg        cfg_q       = '{dsp_result_value: DSP_RESULT_RST, default: '0};

    t_out_item pending_results[$];

    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int mismatches   = 0;
    int words_sent   = 0;
    int writes_sent  = 0;
    int results_seen = 0;
    int cfg_writes   = 0;

    // Strobe number of a one-hot byte: bit k alone gives k+1, anything else 0.
    function automatic logic [3:0] strobe_of(input logic [7:0] v);
        logic [3:0] pos;
        int         ones;
        pos  = 4'd0;
        ones = 0;
        for (int k = 0; k < 8; k++) begin
            if (v[k]) begin
                ones++;
                pos = 4'(k + 1);
            end
        end
        return (ones == 1) ? pos : 4'd0;
    endfunction

    // Reflected CRC-16: fold the byte into the low end, then shift out eight bits.
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    // Apply one bus access to the shadow and return the result word it should produce.
    function automatic t_out_item predict_access(input t_in_item w);
        t_out_item r;
        logic [1:0] st;
        r  = '0;
        st = w.write_data[5:4];
        if (w.mode == MODE_WRITE) begin
            case (w.offset)
                OFF_HIGH_SIDE: begin
                    r.change_mask[CHG_HIGH] = (high_side_q != w.write_data);
                    high_side_q = w.write_data;
                end
                OFF_LEDS: begin
                    r.change_mask[CHG_LEDS] = (led_q != w.write_data);
                    led_q     = w.write_data;
                    led_idx_q = strobe_of(w.write_data);
                end
                OFF_LOW_SIDE: begin
                    // active low: the strobe is the zero bit
                    r.change_mask[CHG_LOW] = (low_side_q != w.write_data);
                    low_side_q = w.write_data;
                    low_idx_q  = strobe_of(~w.write_data);
                end
                OFF_COIN: begin
                    r.change_mask[CHG_COIN] = (coin_q != w.write_data);
                    coin_q = w.write_data;
                end
                OFF_METERS: begin
                    r.change_mask[CHG_METERS] = (meter_q != w.write_data);
                    meter_q = w.write_data;
                end
                OFF_STATUS: begin
                    r.change_mask[CHG_STATUS] = (status_q != st);
                    status_q      = st;
                    r.dsp_command = w.write_data[6];
                end
                OFF_CRC: crc_q = crc16_update(crc_q, w.write_data);
                default: ;
            endcase
        end else begin
            case (w.offset)
                OFF_DSP_RESULT: r.read_data = cfg_q.dsp_result_value;
                OFF_DSP_STATUS: r.read_data = cfg_q.dsp_ready ? cfg_q.dsp_status_value
                                                             : (NOT_READY_FLAG | {1'b0, cfg_q.dsp_revision});
                OFF_CRC_LO_A, OFF_CRC_LO_B: r.read_data = crc_q[7:0];
                OFF_BOARD_REV: r.read_data = cfg_q.board_revision;
                OFF_INPUTS:    r.read_data = {w.switch_nibble, w.pin_inputs};
                OFF_ALL_ONES:  r.read_data = ALL_ONES;
                OFF_COIN_IN:   r.read_data = ~w.coin_inputs;
                default:       r.read_data = 8'h00;
            endcase
        end
        r.high_side_drive  = high_side_q;
        r.low_side_drive   = low_side_q;
        r.low_strobe_index = low_idx_q;
        r.led_drive        = led_q;
        r.led_strobe_index = led_idx_q;
        r.coin_lockout     = coin_q;
        r.meter_drive      = meter_q;
        r.status_leds      = status_q;
        return r;
    endfunction

    function automatic t_in_item bus_word(input logic mode, input logic [3:0] off,
                                          input logic [7:0] data, input logic [3:0] sw,
                                          input logic [7:0] coins, input logic [3:0] pins);
        t_in_item w;
        w.mode          = mode;
        w.offset        = off;
        w.write_data    = data;
        w.switch_nibble = sw;
        w.coin_inputs   = coins;
        w.pin_inputs    = pins;
        return w;
    endfunction

    // Pick write data that reaches the interesting decodes: one-hot, one-cold,
    // a repeat of the latched value (no change), all zeros or ones, or plain noise.
    function automatic logic [7:0] shaped_data(input logic [3:0] off);
        logic [7:0] d;
        d = 8'($urandom_range(255));
        case ($urandom_range(7))
            0: d = 8'h01 << $urandom_range(7);
            1: d = ~(8'h01 << $urandom_range(7));
            2: begin
                case (off)
                    OFF_HIGH_SIDE: d = high_side_q;
                    OFF_LEDS:      d = led_q;
                    OFF_LOW_SIDE:  d = low_side_q;
                    OFF_COIN:      d = coin_q;
                    OFF_METERS:    d = meter_q;
                    OFF_STATUS:    d = {d[7:6], status_q, d[3:0]};
                    default: ;
                endcase
            end
            3: d = $urandom_range(1) ? 8'hFF : 8'h00;
            default: ;
        endcase
        return d;
    endfunction

    // Mostly writes to live registers and reads of live offsets; the rest is
    // any mode at any offset.
    function automatic t_in_item random_access();
        t_in_item w;
        int       pick;
        w = bus_word(MODE_READ, OFF_SPARE_LO, 8'($urandom_range(255)), 4'($urandom_range(15)),
                     8'($urandom_range(255)), 4'($urandom_range(15)));
        pick = $urandom_range(99);
        if (pick < 50) begin
            w.mode = MODE_WRITE;
            case ($urandom_range(6))
                0: w.offset = OFF_HIGH_SIDE;
                1: w.offset = OFF_LEDS;
                2: w.offset = OFF_LOW_SIDE;
                3: w.offset = OFF_COIN;
                4: w.offset = OFF_METERS;
                5: w.offset = OFF_STATUS;
                default: w.offset = OFF_CRC;
            endcase
            w.write_data = shaped_data(w.offset);
        end else if (pick < 85) begin
            case ($urandom_range(7))
                0: w.offset = OFF_DSP_RESULT;
                1: w.offset = OFF_DSP_STATUS;
                2: w.offset = OFF_CRC_LO_A;
                3: w.offset = OFF_CRC_LO_B;
                4: w.offset = OFF_BOARD_REV;
                5: w.offset = OFF_INPUTS;
                6: w.offset = OFF_ALL_ONES;
                default: w.offset = OFF_COIN_IN;
            endcase
        end else begin
            w.mode   = 1'($urandom_range(1));
            w.offset = 4'($urandom_range(15));
        end
        return w;
    endfunction

    // Offer one bus word and hold it until taken. Valid stays high on return so
    // back-to-back words need no gap; drop it with settle_block.
    task automatic send_word(input t_in_item w);
        if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= w.mode;
        i_s_axis_tdata  <= {4'b0000, w.pin_inputs, w.coin_inputs, w.switch_nibble,
                            w.write_data, w.offset};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(predict_access(w));
        words_sent++;
        if (w.mode == MODE_WRITE) writes_sent++;
    endtask

    // Drop valid, wait for every outstanding result, then let the pipeline empty.
    task automatic settle_block();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register and mirror it; valid is left high for a following write.
    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_DSP_RESULT: cfg_q.dsp_result_value = value;
            CFG_DSP_STATUS: cfg_q.dsp_status_value = value;
            CFG_DSP_READY:  cfg_q.dsp_ready        = value[0];
            CFG_DSP_REV:    cfg_q.dsp_revision     = value[6:0];
            CFG_BOARD_REV:  cfg_q.board_revision   = value;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Load a full setting; the bits above the narrow fields carry noise.
    task automatic load_settings(input t_cfg s);
        set_register(CFG_DSP_RESULT, s.dsp_result_value);
        set_register(CFG_DSP_STATUS, s.dsp_status_value);
        set_register(CFG_DSP_READY,  {7'($urandom_range(127)), s.dsp_ready});
        set_register(CFG_DSP_REV,    {1'($urandom_range(1)), s.dsp_revision});
        set_register(CFG_BOARD_REV,  s.board_revision);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_readback();
        send_word(bus_word(MODE_READ, OFF_DSP_RESULT, 8'hFF, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_DSP_STATUS, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_CRC_LO_A,   8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_BOARD_REV,  8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_INPUTS,     8'h00, 4'hF, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_INPUTS,     8'h00, 4'h0, 8'hFF, 4'hF));
        send_word(bus_word(MODE_READ, OFF_ALL_ONES,   8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_COIN_IN,    8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_COIN_IN,    8'h00, 4'hF, 8'hFF, 4'hF));
        send_word(bus_word(MODE_READ, OFF_SPARE_HI,   8'hFF, 4'hF, 8'hFF, 4'hF));
    endtask

    task automatic test_latch_writes();
        send_word(bus_word(MODE_WRITE, OFF_HIGH_SIDE, 8'hFF, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_HIGH_SIDE, 8'hFF, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_COIN,      8'hFF, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_METERS,    8'hFF, 4'h0, 8'h00, 4'h0));
        // status bits and command bit: command with a change, then command
        // dropped with the status bits unchanged, then stray bits only
        send_word(bus_word(MODE_WRITE, OFF_STATUS,    8'h70, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_STATUS,    8'h30, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_STATUS,    8'h8F, 4'h0, 8'h00, 4'h0));
    endtask

    task automatic test_strobe_decode();
        send_word(bus_word(MODE_WRITE, OFF_LEDS,     8'h01, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LEDS,     8'h80, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LEDS,     8'h03, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LOW_SIDE, 8'hFE, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LOW_SIDE, 8'h7F, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LOW_SIDE, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_LOW_SIDE, 8'hFF, 4'h0, 8'h00, 4'h0));
    endtask

    task automatic test_crc_and_spare_writes();
        send_word(bus_word(MODE_WRITE, OFF_CRC,      8'hFF, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_WRITE, OFF_CRC,      8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ,  OFF_CRC_LO_B, 8'h00, 4'h0, 8'h00, 4'h0));
        // writes that land on no register leave every latch alone
        send_word(bus_word(MODE_WRITE, OFF_SPARE_LO, 8'hFF, 4'hF, 8'hFF, 4'hF));
        send_word(bus_word(MODE_WRITE, OFF_COIN_IN,  8'h00, 4'h0, 8'h00, 4'h0));
    endtask

    // Extremes of every register, the revision path, and indexes past the last
    // register that must change nothing.
    task automatic test_register_settings();
        settle_block();
        set_register(CFG_DSP_RESULT, 8'hFF);
        set_register(CFG_DSP_STATUS, 8'hFF);
        set_register(CFG_DSP_READY,  8'hFF);
        set_register(CFG_BOARD_REV,  8'hFF);
        i_cfg_valid <= 1'b0;
        send_word(bus_word(MODE_READ, OFF_DSP_RESULT, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_DSP_STATUS, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_BOARD_REV,  8'h00, 4'h0, 8'h00, 4'h0));
        settle_block();
        set_register(CFG_DSP_READY, 8'hFE);
        set_register(CFG_DSP_REV,   8'hFF);
        for (int k = int'(CFG_BOARD_REV) + 1; k < (1 << CFG_IDX_W); k++) begin
            set_register(CFG_IDX_W'(k), 8'h00);
        end
        i_cfg_valid <= 1'b0;
        send_word(bus_word(MODE_READ, OFF_DSP_STATUS, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_DSP_RESULT, 8'h00, 4'h0, 8'h00, 4'h0));
        send_word(bus_word(MODE_READ, OFF_BOARD_REV,  8'h00, 4'h0, 8'h00, 4'h0));
        settle_block();
    endtask

    // Stall the result side for a long stretch while words keep coming, so the
    // block backs up and drops its input ready.
    task automatic test_backpressure_fill();
        snd_idle_pct = 0;
        hold_request = 150;
        repeat (48) send_word(random_access());
        settle_block();
    endtask

    // Random traffic in chunks; each chunk starts from a fresh setting: all
    // zeros, then all ones, then random values.
    task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                       input int chunks, input int per_chunk);
        t_cfg s;
        for (int c = 0; c < chunks; c++) begin
            settle_block();
            if (c == 0) begin
                s = '0;
            end else if (c == 1) begin
                s = '1;
            end else begin
                s.dsp_result_value = 8'($urandom_range(255));
                s.dsp_status_value = 8'($urandom_range(255));
                s.dsp_ready        = 1'($urandom_range(1));
                s.dsp_revision     = 7'($urandom_range(127));
                s.board_revision   = 8'($urandom_range(255));
            end
            load_settings(s);
            snd_idle_pct = snd_pct;
            rcv_idle_pct = rcv_pct;
            repeat (per_chunk) send_word(random_access());
        end
        settle_block();
    endtask

    // Result side ready: a requested hold wins, otherwise stall at random.
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic flag_field(input string what, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("result word %0d: %s expected %h, got %h", results_seen, what, want, got);
            end
        end
    endtask

    // Compare every accepted result word with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_out_item got;
        t_out_item want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = t_out_item'(o_m_axis_tdata[$bits(t_out_item)-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result word %0d arrived with nothing expected: %h",
                             results_seen, o_m_axis_tdata);
                end
            end else begin
                want = pending_results.pop_front();
                flag_field("read_data",        want.read_data,        got.read_data);
                flag_field("change_mask",      want.change_mask,      got.change_mask);
                flag_field("dsp_command",      want.dsp_command,      got.dsp_command);
                flag_field("high_side_drive",  want.high_side_drive,  got.high_side_drive);
                flag_field("low_side_drive",   want.low_side_drive,   got.low_side_drive);
                flag_field("low_strobe_index", want.low_strobe_index, got.low_strobe_index);
                flag_field("led_drive",        want.led_drive,        got.led_drive);
                flag_field("led_strobe_index", want.led_strobe_index, got.led_strobe_index);
                flag_field("coin_lockout",     want.coin_lockout,     got.coin_lockout);
                flag_field("meter_drive",      want.meter_drive,      got.meter_drive);
                flag_field("status_leds",      want.status_leds,      got.status_leds);
                flag_field("padding", 16'h0000,
                           16'(o_m_axis_tdata[OUT_TDATA_W-1:$bits(t_out_item)]));
            end
        end
    end

    // Hard stop if the block wedges.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_results.size());
        $display("lamp_drive_io_asic_registers_unit regression: fail");
        $finish;
    end

    initial begin
        // Hold reset, then release it for good.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 9;
        rcv_idle_pct = 63;
        test_reset_readback();
        test_latch_writes();
        test_strobe_decode();
        test_crc_and_spare_writes();
        test_register_settings();
        test_backpressure_fill();

        test_random_traffic(9, 63, 3, 180);
        test_random_traffic(63, 9, 3, 180);
        test_random_traffic(0, 0, 3, 180);

        // Let any stray result words show up before judging.
        repeat (8) @(posedge i_clk);
        mismatches += pending_results.size();

        $display("covered %0d bus words (%0d writes), %0d register writes, %0d results checked",
                 words_sent, writes_sent, cfg_writes, results_seen);
        $display("idle mixes: sender-light, receiver-light, none; one long result-side stall");
        if (mismatches == 0) begin
            $display("lamp_drive_io_asic_registers_unit regression: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("lamp_drive_io_asic_registers_unit regression: fail");
        end
        $finish;
    end

endmodule
